[sv/tftp_read_client_step_assert.svh]
// Assertion macros used by the TFTP read client core.
`ifndef TFTP_READ_CLIENT_STEP_ASSERT_SVH
`define TFTP_READ_CLIENT_STEP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tftp_rc_pkg.sv]
// Types and constants of the TFTP read client.
package tftp_rc_pkg;

    localparam logic [15:0] OP_DATA    = 16'd3;
    localparam logic [15:0] OP_ACK     = 16'd4;
    localparam logic [15:0] OP_ERR     = 16'd5;
    localparam logic [15:0] OP_OACK    = 16'd6;
    localparam logic [15:0] BS_DEFAULT = 16'd512;
    localparam logic [15:0] BS_LOWEST  = 16'd8;
    localparam logic [15:0] BS_HIGHEST = 16'd65464;
    localparam logic [15:0] HDR_BYTES  = 16'd4;
    localparam logic [15:0] LEN_MIN    = 16'd2;

    localparam logic ITEM_START    = 1'b0;
    localparam logic ITEM_DATAGRAM = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_DATA   = 2'd2,
        PH_CLOSED = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ACT_IGNORE  = 3'd0,
        ACT_REQUEST = 3'd1,
        ACT_ACK     = 3'd2,
        ACT_FINAL   = 3'd3,
        ACT_ERROR   = 3'd4
    } t_action;

    typedef struct packed {
        logic        op;
        logic [15:0] packet_length;
        logic [15:0] packet_opcode;
        logic [15:0] packet_block;
        logic [15:0] source_port;
    } t_in_item;

    typedef struct packed {
        t_action     action;
        logic [15:0] ack_block;
        logic        lock_peer;
        logic [15:0] peer_port;
        logic [15:0] request_block_size;
    } t_result;

endpackage

[sv/tftp_rc_in_if.sv]
// Input channel: one received datagram header or a start request per word.
interface tftp_rc_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] packet_length;
    logic [15:0] packet_opcode;
    logic [15:0] packet_block;
    logic [15:0] source_port;

    modport source (output valid, op, packet_length, packet_opcode, packet_block,
                    source_port, input ready);
    modport sink (input valid, op, packet_length, packet_opcode, packet_block,
                  source_port, output ready);
endinterface

[sv/tftp_rc_out_if.sv]
// Output channel: one decision word per accepted input word.
interface tftp_rc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [15:0] ack_block;
    logic        lock_peer;
    logic [15:0] peer_port;
    logic [15:0] request_block_size;

    modport source (output valid, action, ack_block, lock_peer, peer_port,
                    request_block_size, input ready);
    modport sink (input valid, action, ack_block, lock_peer, peer_port,
                  request_block_size, output ready);
endinterface

[sv/tftp_read_client_step.sv]
// An accepted input word is held in the input register; its result word is then loaded into the result register.
// Throughput: one word per cycle; the state update for a word completes in the
// cycle it leaves the input register, so the next word sees it at once.
// Backpressure stalls only when the result register is full and not being drained.
// Synchronous active-low reset: transfer idle, counter and port zero, block size 512,
// requested block size register 512, both channel stages empty.
module tftp_read_client_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_wdata,
    tftp_rc_in_if.sink    i_in,
    tftp_rc_out_if.source o_out
);
    logic                  in_valid;
    tftp_rc_pkg::t_in_item in_item;
    logic                  out_space;
    logic                  fire;
    tftp_rc_pkg::t_result  res;

    assign fire = in_valid && out_space;

    tftp_rc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (fire),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    tftp_rc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_item      (in_item),
        .o_res       (res)
    );

    tftp_rc_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_res   (res),
        .o_space (out_space),
        .o_out   (o_out)
    );
endmodule

[sv/tftp_rc_in_stage.sv]
// Input register stage that holds one word until the decision logic takes it.
module tftp_rc_in_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tftp_rc_in_if.sink            i_in,
    input  logic                  i_take,
    output logic                  o_valid,
    output tftp_rc_pkg::t_in_item o_item
);
    logic                  r_valid;
    logic                  n_valid;
    tftp_rc_pkg::t_in_item r_item;
    logic                  accept;

    // The register frees up in the same cycle its word is consumed.
    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        priority if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= '{op: i_in.op, packet_length: i_in.packet_length,
                        packet_opcode: i_in.packet_opcode, packet_block: i_in.packet_block,
                        source_port: i_in.source_port};
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

[sv/tftp_rc_core.sv]
// Transfer state registers and the per-word decision logic.
module tftp_rc_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [15:0]           i_cfg_wdata,
    input  logic                  i_fire,
    input  tftp_rc_pkg::t_in_item i_item,
    output tftp_rc_pkg::t_result  o_res
);
    `include "tftp_read_client_step_assert.svh"

    logic [15:0]         r_req_bs;
    tftp_rc_pkg::t_phase r_phase;
    tftp_rc_pkg::t_phase n_phase;
    logic [15:0]         r_block_counter;
    logic [15:0]         n_block_counter;
    logic [15:0]         r_locked_port;
    logic [15:0]         n_locked_port;
    logic [15:0]         r_active_bs;
    logic [15:0]         n_active_bs;
    tftp_rc_pkg::t_action n_action;

    logic        is_start;
    logic        dg_live;
    logic        is_err;
    logic        is_oack;
    logic        is_data;
    logic        take_first;
    logic        take_data;
    logic        taken;
    logic        lock;
    logic        len_hdr_ok;
    logic        blk_adv;
    logic [15:0] counter_inc;
    logic [15:0] bs_eff;
    logic [15:0] bs_start;
    logic [16:0] expected;

    assign is_start   = (i_item.op == tftp_rc_pkg::ITEM_START);
    assign dg_live    = (r_phase == tftp_rc_pkg::PH_FIRST || r_phase == tftp_rc_pkg::PH_DATA)
                        && (i_item.packet_length >= tftp_rc_pkg::LEN_MIN);
    assign is_err     = (i_item.packet_opcode == tftp_rc_pkg::OP_ERR);
    assign is_oack    = (i_item.packet_opcode == tftp_rc_pkg::OP_OACK);
    assign is_data    = (i_item.packet_opcode == tftp_rc_pkg::OP_DATA);
    assign take_first = (r_phase == tftp_rc_pkg::PH_FIRST) && (is_oack || is_data);
    assign take_data  = (r_phase == tftp_rc_pkg::PH_DATA) && is_data
                        && (i_item.source_port == r_locked_port);
    assign taken      = dg_live && !is_err && (take_first || take_data);
    // The datagram fields of a start word are not a reply and never lock the peer.
    assign lock       = !is_start && dg_live && !is_err && take_first;
    assign len_hdr_ok = (i_item.packet_length >= tftp_rc_pkg::HDR_BYTES);
    assign counter_inc = r_block_counter + 16'd1;
    // The counter moves before the length check, so an oversized block still counts.
    assign blk_adv    = taken && !is_oack && len_hdr_ok && (i_item.packet_block == counter_inc);
    // A DATA packet as first reply means the server refused the option.
    assign bs_eff     = (lock && is_data) ? tftp_rc_pkg::BS_DEFAULT : r_active_bs;
    assign expected   = {1'b0, tftp_rc_pkg::HDR_BYTES} + {1'b0, bs_eff};
    assign bs_start   = (r_req_bs < tftp_rc_pkg::BS_LOWEST || r_req_bs > tftp_rc_pkg::BS_HIGHEST)
                        ? tftp_rc_pkg::BS_DEFAULT : r_req_bs;

    // Output decision.
    always_comb begin
        priority if (is_start) begin
            n_action = tftp_rc_pkg::ACT_REQUEST;
        end else if (!dg_live) begin
            n_action = tftp_rc_pkg::ACT_IGNORE;
        end else if (is_err) begin
            n_action = tftp_rc_pkg::ACT_ERROR;
        end else if (!taken) begin
            n_action = tftp_rc_pkg::ACT_IGNORE;
        end else if (is_oack) begin
            n_action = tftp_rc_pkg::ACT_ACK;
        end else if (!len_hdr_ok) begin
            n_action = tftp_rc_pkg::ACT_IGNORE;
        end else if ({1'b0, i_item.packet_length} == expected) begin
            n_action = tftp_rc_pkg::ACT_ACK;
        end else if ({1'b0, i_item.packet_length} < expected) begin
            n_action = tftp_rc_pkg::ACT_FINAL;
        end else begin
            n_action = tftp_rc_pkg::ACT_IGNORE;
        end
    end

    // Next state.
    always_comb begin
        unique case (n_action)
            tftp_rc_pkg::ACT_REQUEST: n_phase = tftp_rc_pkg::PH_FIRST;
            tftp_rc_pkg::ACT_ACK:     n_phase = tftp_rc_pkg::PH_DATA;
            tftp_rc_pkg::ACT_FINAL,
            tftp_rc_pkg::ACT_ERROR:   n_phase = tftp_rc_pkg::PH_CLOSED;
            default:                  n_phase = r_phase;
        endcase
        priority if (is_start) begin
            n_block_counter = '0;
            n_locked_port   = '0;
            n_active_bs     = bs_start;
        end else begin
            n_block_counter = blk_adv ? counter_inc : r_block_counter;
            n_locked_port   = lock ? i_item.source_port : r_locked_port;
            n_active_bs     = bs_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_bs        <= tftp_rc_pkg::BS_DEFAULT;
            r_phase         <= tftp_rc_pkg::PH_IDLE;
            r_block_counter <= '0;
            r_locked_port   <= '0;
            r_active_bs     <= tftp_rc_pkg::BS_DEFAULT;
        end else begin
            if (i_cfg_we) begin
                r_req_bs <= i_cfg_wdata;
            end
            if (i_fire) begin
                r_phase         <= n_phase;
                r_block_counter <= n_block_counter;
                r_locked_port   <= n_locked_port;
                r_active_bs     <= n_active_bs;
            end
        end
    end

    assign o_res = '{action: n_action, ack_block: n_block_counter, lock_peer: lock,
                     peer_port: n_locked_port, request_block_size: n_active_bs};

    `TRC_ASSERT_NEXT(a_start_restarts, i_clk, i_rst_n, i_fire && is_start,
        r_phase == tftp_rc_pkg::PH_FIRST && r_block_counter == '0 && r_locked_port == '0,
        "start did not restart the transfer")
    `TRC_ASSERT_NEXT(a_error_closes, i_clk, i_rst_n, i_fire && n_action == tftp_rc_pkg::ACT_ERROR,
        r_phase == tftp_rc_pkg::PH_CLOSED, "error reply did not close the transfer")
    `TRC_ASSERT_NOW(a_lock_only_first, i_clk, i_rst_n, lock,
        r_phase == tftp_rc_pkg::PH_FIRST && !is_start, "peer locked outside the first reply")
endmodule

[sv/tftp_rc_out_stage.sv]
// Result register that holds one decision until the consumer takes it.
module tftp_rc_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  tftp_rc_pkg::t_result i_res,
    output logic                 o_space,
    tftp_rc_out_if.source        o_out
);
    logic                 r_valid;
    logic                 n_valid;
    tftp_rc_pkg::t_result r_res;

    assign o_space = !r_valid || o_out.ready;

    always_comb begin
        priority if (i_load) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid              = r_valid;
    assign o_out.action             = r_res.action;
    assign o_out.ack_block          = r_res.ack_block;
    assign o_out.lock_peer          = r_res.lock_peer;
    assign o_out.peer_port          = r_res.peer_port;
    assign o_out.request_block_size = r_res.request_block_size;
endmodule
